@@ hdl/rdpl_pkg.sv @@
// ----------------------------------------------------------------------------
// rdpl_pkg
// Shared types and constants for the raw difference, prediction and
// linearization unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rdpl_pkg;

  // Curve store geometry.
  localparam int SAMPLE_BITS = 14;
  localparam int CURVE_DEPTH = 1 << SAMPLE_BITS;

  // Work queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef logic [SAMPLE_BITS-1:0] curve_addr_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROW_WIDTH   = 3'd0,
    CFG_VERT_EE     = 3'd1,
    CFG_VERT_EO     = 3'd2,
    CFG_VERT_OE     = 3'd3,
    CFG_VERT_OO     = 3'd4,
    CFG_VALUE_LIMIT = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_kind_t;

  // One unit of work handed from the front to the back part.
  typedef struct packed {
    req_kind_t   kind;
    curve_addr_t addr;
    logic [15:0] value;
    logic        err;
    logic        eor;
  } work_t;

endpackage

`default_nettype wire

@@ hdl/rdpl_ram.sv @@
// ----------------------------------------------------------------------------
// rdpl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rdpl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/rdpl_front.sv @@
// ----------------------------------------------------------------------------
// rdpl_front
// Accepts requests, rebuilds differences, updates the predictors and the
// row position, and hands curve loads and lookups to the work queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rdpl_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic [rdpl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [rdpl_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               in_accept,
  input  wire logic                               req_type,
  input  wire logic                               first_of_frame,
  input  wire logic [7:0]                         code_symbol,
  input  wire logic [14:0]                        extra_bits,
  input  wire logic [13:0]                        curve_index,
  input  wire logic [15:0]                        curve_value,
  output logic                                    push,
  output rdpl_pkg::work_t                         work
);

  logic [14:0] row_width;
  logic [15:0] vert_init [4];
  logic [14:0] value_limit;

  logic [15:0] vert_pred [4];
  logic [15:0] horz_pred [2];
  logic [13:0] col;
  logic        row_par;
  logic        sticky;

  logic [15:0] vert_pred_next [4];
  logic [15:0] horz_pred_next [2];
  logic [13:0] col_next;
  logic        row_par_next;
  logic        sticky_next;

  logic [15:0] vert_cur [4];
  logic [15:0] horz_cur [2];
  logic [13:0] col_cur;
  logic        par_cur;
  logic        sticky_cur;
  logic        restart;
  logic        is_sample;
  logic        is_vert;
  logic [1:0]  vidx;
  logic [15:0] diff;
  logic [15:0] vsum;
  logic [15:0] hsum;
  logic [15:0] pred;
  logic        err_now;
  logic [14:0] width_eff;
  logic [14:0] last_col;
  logic        eor;

  // Rebuilds the signed difference, kept modulo 2^16 since it only feeds
  // a 16-bit predictor add.
  function automatic logic [15:0] rebuild_diff(input logic [7:0]  sym,
                                               input logic [14:0] extra);
    logic [3:0]  len;
    logic [3:0]  shl;
    logic [3:0]  nbits;
    logic [14:0] mask;
    logic [14:0] bits;
    logic [31:0] t;
    logic [15:0] mag;
    logic [15:0] bias;
    len   = sym[3:0];
    shl   = sym[7:4];
    nbits = (shl <= len) ? (len - shl) : 4'd0;
    mask  = 15'((16'd1 << nbits) - 16'd1);
    bits  = extra & mask;
    t     = {16'd0, bits, 1'b1} << shl;
    mag   = t[16:1];
    bias  = (16'd1 << len) - {15'd0, (shl == 4'd0)};
    if (len == 4'd0) begin
      return 16'd0;
    end else if (!mag[len - 4'd1]) begin
      return mag - bias;
    end else begin
      return mag;
    end
  endfunction

  always_comb begin
    is_sample = (rdpl_pkg::req_kind_t'(req_type) == rdpl_pkg::REQ_SAMPLE);
    restart   = first_of_frame;

    for (int i = 0; i < 4; i++) begin
      vert_cur[i] = restart ? vert_init[i] : vert_pred[i];
    end
    for (int i = 0; i < 2; i++) begin
      horz_cur[i] = restart ? 16'd0 : horz_pred[i];
    end
    col_cur    = restart ? 14'd0 : col;
    par_cur    = restart ? 1'b0 : row_par;
    sticky_cur = restart ? 1'b0 : sticky;

    diff    = rebuild_diff(code_symbol, extra_bits);
    is_vert = (col_cur[13:1] == 13'd0);
    vidx    = {par_cur, col_cur[0]};
    vsum    = vert_cur[vidx] + diff;
    hsum    = horz_cur[col_cur[0]] + diff;
    pred    = is_vert ? vsum : hsum;

    err_now = (pred >= {1'b0, value_limit}) ||
              (17'(pred) >= 17'(rdpl_pkg::CURVE_DEPTH));

    if (row_width < 15'd2) begin
      width_eff = 15'd2;
    end else if (row_width > 15'd16384) begin
      width_eff = 15'd16384;
    end else begin
      width_eff = row_width;
    end
    last_col = width_eff - 15'd1;
    eor      = ({1'b0, col_cur} >= last_col);

    vert_pred_next = vert_cur;
    if (is_vert) begin
      vert_pred_next[vidx] = vsum;
    end
    horz_pred_next              = horz_cur;
    horz_pred_next[col_cur[0]]  = pred;
    col_next     = eor ? 14'd0 : (col_cur + 14'd1);
    row_par_next = eor ? ~par_cur : par_cur;
    sticky_next  = sticky_cur | err_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width   <= 15'd4096;
      value_limit <= 15'd16384;
      for (int i = 0; i < 4; i++) begin
        vert_init[i] <= 16'd0;
        vert_pred[i] <= 16'd0;
      end
      horz_pred[0] <= 16'd0;
      horz_pred[1] <= 16'd0;
      col          <= 14'd0;
      row_par      <= 1'b0;
      sticky       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (rdpl_pkg::cfg_reg_t'(cfg_index))
          rdpl_pkg::CFG_ROW_WIDTH:   row_width    <= cfg_data[14:0];
          rdpl_pkg::CFG_VERT_EE:     vert_init[0] <= cfg_data;
          rdpl_pkg::CFG_VERT_EO:     vert_init[1] <= cfg_data;
          rdpl_pkg::CFG_VERT_OE:     vert_init[2] <= cfg_data;
          rdpl_pkg::CFG_VERT_OO:     vert_init[3] <= cfg_data;
          rdpl_pkg::CFG_VALUE_LIMIT: value_limit  <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (in_accept && is_sample) begin
        vert_pred <= vert_pred_next;
        horz_pred <= horz_pred_next;
        col       <= col_next;
        row_par   <= row_par_next;
        sticky    <= sticky_next;
      end
    end
  end

  always_comb begin
    push = in_accept;
    if (is_sample) begin
      work.kind  = rdpl_pkg::REQ_SAMPLE;
      work.addr  = pred[rdpl_pkg::SAMPLE_BITS-1:0];
      work.value = curve_value;
      work.err   = sticky_next;
      work.eor   = eor;
    end else begin
      work.kind  = rdpl_pkg::REQ_LOAD;
      work.addr  = rdpl_pkg::curve_addr_t'(curve_index);
      work.value = curve_value;
      work.err   = 1'b0;
      work.eor   = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rdpl_queue.sv @@
// ----------------------------------------------------------------------------
// rdpl_queue
// Short first-in first-out queue of work between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module rdpl_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire rdpl_pkg::work_t  push_work,
  output logic                  full,
  output logic                  head_valid,
  output rdpl_pkg::work_t       head_work,
  input  wire logic             pop
);

  rdpl_pkg::work_t                    slots [rdpl_pkg::QUEUE_DEPTH];
  logic [rdpl_pkg::QUEUE_PTR_W-1:0]   wr_ptr;
  logic [rdpl_pkg::QUEUE_PTR_W-1:0]   rd_ptr;
  logic [rdpl_pkg::QUEUE_CNT_W-1:0]   count;

  assign full       = (count == rdpl_pkg::QUEUE_CNT_W'(rdpl_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_work  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_work;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + rdpl_pkg::QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + rdpl_pkg::QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + rdpl_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - rdpl_pkg::QUEUE_CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("work pushed into a full queue");

endmodule

`default_nettype wire

@@ hdl/rdpl_back.sv @@
// ----------------------------------------------------------------------------
// rdpl_back
// Carries out queued work in order: writes curve entries, looks up pixels
// and holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rdpl_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire rdpl_pkg::work_t  head_work,
  output logic                  pop,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [15:0]           m_tdata,
  output logic                  m_tuser,
  output logic                  m_tlast
);

  logic        lookup_valid;
  logic        lookup_err;
  logic        lookup_eor;
  logic        out_free;
  logic        lookup_adv;
  logic        is_load;
  logic        ram_we;
  logic        ram_re;
  logic [15:0] ram_rdata;

  assign out_free   = !m_tvalid || m_tready;
  assign lookup_adv = !lookup_valid || out_free;
  assign is_load    = (head_work.kind == rdpl_pkg::REQ_LOAD);

  // Loads never wait on the result path; lookups wait for room downstream.
  assign pop    = head_valid && (is_load || lookup_adv);
  assign ram_we = pop && is_load;
  assign ram_re = pop && !is_load;

  rdpl_ram #(
    .WIDTH (16),
    .DEPTH (rdpl_pkg::CURVE_DEPTH)
  ) u_curve (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_work.addr),
    .wdata (head_work.value),
    .re    (ram_re),
    .raddr (head_work.addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lookup_valid <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (ram_re) begin
        lookup_valid <= 1'b1;
      end else if (out_free) begin
        lookup_valid <= 1'b0;
      end
      if (out_free) begin
        m_tvalid <= lookup_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      lookup_err <= head_work.err;
      lookup_eor <= head_work.eor;
    end
    if (out_free && lookup_valid) begin
      m_tdata <= lookup_err ? 16'd0 : ram_rdata;
      m_tuser <= lookup_err;
      m_tlast <= lookup_eor;
    end
  end

  a_lookup_holds: assert property (@(posedge clk) disable iff (rst)
    lookup_valid && !out_free |=> lookup_valid && $stable(ram_rdata))
    else $error("pending curve lookup lost while output stalled");

  a_one_port_op: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("curve write and lookup issued together");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 16'd0)
    else $error("pixel not zero while in range error");

endmodule

`default_nettype wire

@@ hdl/raw_diff_predict_linearize_unit.sv @@
// ----------------------------------------------------------------------------
// raw_diff_predict_linearize_unit
// Rebuilds differences, predicts samples and linearizes them through a
// loaded curve; one pixel per sample request, none per curve load.
// ----------------------------------------------------------------------------
// A sample's pixel passes the work queue, the curve RAM read register and the
// output register. Throughput: one request per cycle while the four-entry
// queue has room; the RAM serves one load or one unstalled lookup per cycle.
// Reset clears the predictors, row position, error flag, registers and
// queue. The curve store is not cleared and must be loaded before use.
`default_nettype none

module raw_diff_predict_linearize_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [rdpl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [rdpl_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [7:0] code_symbol, [22:8] extra_bits, [36:23] curve_index,
  // [52:37] curve_value, [55:53] zero
  input  wire logic [55:0]                       s_tdata,
  // [0] req_type, [1] first_of_frame
  input  wire logic [1:0]                        s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [15:0] pixel_value
  output logic [15:0]                            m_tdata,
  // [0] range_error
  output logic                                   m_tuser,
  output logic                                   m_tlast
);

  logic            in_accept;
  logic            push;
  rdpl_pkg::work_t push_work;
  logic            q_full;
  logic            head_valid;
  rdpl_pkg::work_t head_work;
  logic            pop;

  assign s_tready  = !q_full;
  assign in_accept = s_tvalid && s_tready;

  rdpl_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_accept      (in_accept),
    .req_type       (s_tuser[0]),
    .first_of_frame (s_tuser[1]),
    .code_symbol    (s_tdata[7:0]),
    .extra_bits     (s_tdata[22:8]),
    .curve_index    (s_tdata[36:23]),
    .curve_value    (s_tdata[52:37]),
    .push           (push),
    .work           (push_work)
  );

  rdpl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_work  (push_work),
    .full       (q_full),
    .head_valid (head_valid),
    .head_work  (head_work),
    .pop        (pop)
  );

  rdpl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_work  (head_work),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

@@ test/raw_diff_predict_linearize_checker.sv @@
// ----------------------------------------------------------------------------
// raw_diff_predict_linearize_checker
// Watches the request, pixel and configuration ports of the unit, keeps its
// own copy of the predictors, row position and curve, and compares every
// pixel with the expected one field by field, the value only where it is known.
// ----------------------------------------------------------------------------

module raw_diff_predict_linearize_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [rdpl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rdpl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [55:0]                      s_tdata,
  input  logic [1:0]                       s_tuser,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [15:0]                      m_tdata,
  input  logic                             m_tuser,
  input  logic                             m_tlast,
  output int                               mismatches,
  output int                               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] pixel;
    logic        known;
    logic        range_err;
    logic        row_end;
  } pixel_t;

  logic [14:0] row_width_q;
  logic [14:0] limit_q;
  logic [15:0] vert_init [4];
  logic [15:0] vert_pred [4];
  logic [15:0] horz_pred [2];
  logic [13:0] col_q;
  logic        row_odd;
  logic        sticky_err;
  logic [15:0] curve [rdpl_pkg::CURVE_DEPTH];
  bit          loaded [rdpl_pkg::CURVE_DEPTH];
  pixel_t      expected_pixels [$];

  // Signed difference from a length/shift symbol and its raw extra bits.
  function automatic int symbol_diff(logic [7:0] sym, logic [14:0] extra);
    int unsigned len, shl, nbits, bits, mag;
    int diff;
    len = sym[3:0];
    shl = sym[7:4];
    nbits = (shl <= len) ? len - shl : 0;
    bits = extra & ((32'd1 << nbits) - 1);
    mag = (((bits << 1) | 1) << shl) >> 1;
    if (len == 0)
      return 0;
    diff = int'(mag);
    if ((mag & (32'd1 << (len - 1))) == 0)
      diff -= (1 << len) - ((shl == 0) ? 1 : 0);
    return diff;
  endfunction

  function automatic void predict_pixel(logic new_frame, logic [7:0] sym, logic [14:0] extra);
    int unsigned width, col;
    logic [31:0] diff;
    logic [15:0] pred;
    logic [1:0]  v;
    pixel_t      px;
    if (new_frame) begin
      for (int i = 0; i < 4; i++)
        vert_pred[i] = vert_init[i];
      horz_pred[0] = '0;
      horz_pred[1] = '0;
      col_q = '0;
      row_odd = 1'b0;
      sticky_err = 1'b0;
    end
    width = row_width_q;
    if (width < 2)
      width = 2;
    if (width > rdpl_pkg::CURVE_DEPTH)
      width = rdpl_pkg::CURVE_DEPTH;
    col = col_q;
    diff = symbol_diff(sym, extra);
    // The first two columns seed the horizontal predictors from the vertical ones.
    if (col < 2) begin
      v = {row_odd, col[0]};
      vert_pred[v] = vert_pred[v] + diff[15:0];
      horz_pred[col[0]] = vert_pred[v];
      pred = vert_pred[v];
    end else begin
      horz_pred[col[0]] = horz_pred[col[0]] + diff[15:0];
      pred = horz_pred[col[0]];
    end
    if (pred >= limit_q || pred >= rdpl_pkg::CURVE_DEPTH)
      sticky_err = 1'b1;
    px.row_end = (col >= width - 1);
    if (px.row_end) begin
      col_q = '0;
      row_odd = ~row_odd;
    end else begin
      col_q = 14'(col + 1);
    end
    px.range_err = sticky_err;
    // A pixel from a curve entry that was never loaded has no defined value.
    px.known = sticky_err || loaded[pred[rdpl_pkg::SAMPLE_BITS-1:0]];
    px.pixel = sticky_err ? 16'h0000 : curve[pred[rdpl_pkg::SAMPLE_BITS-1:0]];
    expected_pixels.insert(expected_pixels.size(), px);
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      row_width_q = 15'd4096;
      limit_q = 15'd16384;
      for (int i = 0; i < 4; i++) begin
        vert_init[i] = '0;
        vert_pred[i] = '0;
      end
      horz_pred[0] = '0;
      horz_pred[1] = '0;
      col_q = '0;
      row_odd = 1'b0;
      sticky_err = 1'b0;
      expected_pixels.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          rdpl_pkg::CFG_ROW_WIDTH:   row_width_q = cfg_data[14:0];
          rdpl_pkg::CFG_VERT_EE:     vert_init[0] = cfg_data;
          rdpl_pkg::CFG_VERT_EO:     vert_init[1] = cfg_data;
          rdpl_pkg::CFG_VERT_OE:     vert_init[2] = cfg_data;
          rdpl_pkg::CFG_VERT_OO:     vert_init[3] = cfg_data;
          rdpl_pkg::CFG_VALUE_LIMIT: limit_q = cfg_data[14:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, actual %h err %b eor %b",
                   $time, m_tdata, m_tuser, m_tlast);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (want.known && m_tdata !== want.pixel) begin
            $display("%0t: pixel_value expected %h actual %h", $time, want.pixel, m_tdata);
            mismatches++;
          end
          if (m_tuser !== want.range_err) begin
            $display("%0t: range_error expected %b actual %b", $time, want.range_err, m_tuser);
            mismatches++;
          end
          if (m_tlast !== want.row_end) begin
            $display("%0t: end_of_row expected %b actual %b", $time, want.row_end, m_tlast);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == rdpl_pkg::REQ_LOAD) begin
          curve[s_tdata[36:23]] = s_tdata[52:37];
          loaded[s_tdata[36:23]] = 1'b1;
        end else begin
          predict_pixel(s_tuser[1], s_tdata[7:0], s_tdata[22:8]);
        end
      end
    end
    outstanding = expected_pixels.size();
  end

endmodule

@@ test/raw_diff_predict_linearize_unit_tb.sv @@
// ----------------------------------------------------------------------------
// raw_diff_predict_linearize_unit_tb
// Loads the curve entries that a directed set of symbols looks up, runs those
// symbols through the predictors, then random load and sample requests under
// several register settings and idle patterns; the checker predicts and
// compares each pixel.
// ----------------------------------------------------------------------------

module raw_diff_predict_linearize_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 4000;
  localparam int DIRECTED_LOADS = 8;
  localparam logic [13:0] DIRECTED_ADDR [DIRECTED_LOADS] = '{
    14'd100, 14'd199, 14'd101, 14'd203, 14'd16012, 14'd16383, 14'd200, 14'd69
  };

  logic                             clk;
  logic                             rst;
  logic                             cfg_wr_en;
  logic [rdpl_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [rdpl_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [55:0]                      s_tdata;
  logic [1:0]                       s_tuser;
  logic                             m_tvalid;
  logic                             m_tready;
  logic [15:0]                      m_tdata;
  logic                             m_tuser;
  logic                             m_tlast;

  int mismatches;
  int outstanding;
  int send_idle_pct;
  int stall_pct;
  int quiet_cycles;

  raw_diff_predict_linearize_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  raw_diff_predict_linearize_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99, 0) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send(input rdpl_pkg::req_kind_t kind, input logic new_frame,
                      input logic [7:0] sym, input logic [14:0] extra,
                      input logic [13:0] addr, input logic [15:0] val);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= {new_frame, kind};
    s_tdata <= {3'b000, val, addr, extra, sym};
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
  endtask

  task automatic sample(input logic new_frame, input logic [7:0] sym, input logic [14:0] extra);
    send(rdpl_pkg::REQ_SAMPLE, new_frame, sym, extra, 14'($urandom), 16'($urandom));
  endtask

  task automatic load(input logic new_frame, input logic [13:0] addr, input logic [15:0] val);
    send(rdpl_pkg::REQ_LOAD, new_frame, 8'($urandom), 15'($urandom), addr, val);
  endtask

  // Holds off the sender until every pixel is out and the queued loads have settled.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] width, input logic [15:0] ee, input logic [15:0] eo,
                           input logic [15:0] oe, input logic [15:0] oo,
                           input logic [15:0] limit);
    logic [15:0]        vals [6];
    rdpl_pkg::cfg_reg_t sel;
    vals = '{width, ee, eo, oe, oo, limit};
    sel = rdpl_pkg::CFG_ROW_WIDTH;
    for (int i = 0; i < 6; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= sel;
      cfg_data <= vals[i];
      @(posedge clk);
      sel = sel.next();
    end
    // Indexes past the last register must not disturb anything.
    for (int k = int'(rdpl_pkg::CFG_VALUE_LIMIT) + 1; k < (1 << rdpl_pkg::CFG_INDEX_W); k++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= rdpl_pkg::CFG_INDEX_W'(k);
      cfg_data <= 16'($urandom);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly short symbols without shift, so predictors stay in range for a while.
  function automatic logic [7:0] random_symbol();
    logic [3:0] len, shl;
    if ($urandom_range(99, 0) < 20)
      return 8'($urandom);
    len = 4'($urandom_range(7, 0));
    shl = ($urandom_range(99, 0) < 80) ? 4'd0 : 4'($urandom_range(len, 0));
    return {shl, len};
  endfunction

  // Half of the loads land close to a current predictor so that later pixels
  // are likely to read an entry that holds a known value.
  function automatic logic [13:0] load_address();
    logic [15:0] base;
    if ($urandom_range(1, 0) == 0)
      return 14'($urandom);
    if ($urandom_range(1, 0) == 0)
      base = i_checker.vert_pred[$urandom_range(3, 0)];
    else
      base = i_checker.horz_pred[$urandom_range(1, 0)];
    return 14'(base + 16'($urandom_range(16, 0)) - 16'd8);
  endfunction

  task automatic random_requests(input int count, input bit hold_midway);
    for (int n = 0; n < count; n++) begin
      if (hold_midway && n == count / 2)
        drain();
      if ($urandom_range(99, 0) < 12)
        load(1'($urandom_range(1, 0)), load_address(), 16'($urandom));
      else
        sample($urandom_range(99, 0) < 5, random_symbol(), 15'($urandom));
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    configure(16'd4, 16'd100, 16'd200, 16'd16000, 16'd16383, 16'd16384);
    // The curve entries that the directed samples look up are written first.
    for (int a = 0; a < DIRECTED_LOADS; a++)
      load(1'($urandom_range(1, 0)), DIRECTED_ADDR[a], 16'($urandom));

    sample(1'b1, 8'h00, 15'h7fff);  // zero length
    sample(1'b0, 8'h01, 15'h0000);  // one bit, negative
    sample(1'b0, 8'h01, 15'h0001);  // one bit, positive
    sample(1'b0, 8'h33, 15'h7fff);  // shift equal to length, row end
    sample(1'b0, 8'h52, 15'h7fff);  // shift above length
    sample(1'b0, 8'h21, 15'h0000);  // lands on the top curve entry
    sample(1'b0, 8'h0f, 15'h7fff);  // largest positive step, out of range
    sample(1'b0, 8'h0f, 15'h0000);  // largest negative step, error stays
    load(1'b1, 14'd5, 16'habcd);    // frame flag on a load is ignored
    sample(1'b1, 8'h00, 15'h0000);
    sample(1'b0, 8'hf0, 15'h7fff);  // zero length with a shift
    sample(1'b0, 8'h0f, 15'h0000);  // predictor wraps below zero
    sample(1'b1, 8'h05, 15'h0000);
    load(1'b0, 14'd200, 16'h0000);
    sample(1'b0, 8'h00, 15'h0000);  // reads the entry just rewritten
    load(1'b0, 14'd100, 16'hffff);
    sample(1'b1, 8'h00, 15'h0000);
    sample(1'b0, 8'hff, 15'h7fff);
    drain();

    configure(16'd2, 16'd0, 16'd1, 16'd16383, 16'd8191, 16'd16384);
    random_requests(90, 1'b0);
    drain();

    configure(16'd0, 16'd1000, 16'd2000, 16'd3000, 16'd4000, 16'd1);
    send_idle_pct = 59;
    random_requests(60, 1'b0);
    drain();

    configure(16'd7, 16'd4000, 16'd4100, 16'd4200, 16'd4300, 16'd8000);
    send_idle_pct = 0;
    stall_pct = 59;
    random_requests(100, 1'b1);
    drain();

    configure(16'd16384, 16'hffff, 16'h8000, 16'h0000, 16'h7fff, 16'd0);
    send_idle_pct = 23;
    stall_pct = 23;
    random_requests(60, 1'b0);
    drain();

    configure(16'hffff, 16'd12000, 16'd12001, 16'd11999, 16'd12002, 16'h7fff);
    send_idle_pct = 0;
    stall_pct = 0;
    random_requests(90, 1'b0);
    drain();

    configure(16'd1, 16'd8000, 16'd8000, 16'd8000, 16'd8000, 16'd16383);
    send_idle_pct = 23;
    stall_pct = 23;
    random_requests(100, 1'b0);
    drain();

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
